[rtl/rgb_pkg.sv]
`timescale 1ns / 1ps
// rgb_pkg: shared constants, types and helper functions of the bar pixel generator
// no dependencies

package rgb_pkg;

  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 24;
  localparam int ColW       = 6;
  localparam int RowW       = 5;
  localparam int WidthW     = 7;
  localparam int HeightW    = 5;
  localparam int ColorW     = 32;
  localparam int ChanW      = 8;
  localparam int NumChan    = 4;
  localparam int MagW       = 13;
  localparam int RecipShift = 16;
  localparam int RecipW     = 17;
  localparam int ProdW      = MagW + RecipW;
  localparam int CfgIdxW    = 3;
  localparam int Stages     = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBarWidth    = 3'd0,
    CfgBarHeight   = 3'd1,
    CfgTopColor    = 3'd2,
    CfgBottomColor = 3'd3,
    CfgBorderColor = 3'd4,
    CfgRoundedMode = 3'd5,
    CfgPatternMode = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic err;
    logic hide;
    logic stripe;
    logic border;
  } geo_flags_t;

  // floor(2^16 / d) for the gradient divisor
  function automatic logic [RecipW-1:0] recip(input logic [HeightW-1:0] d);
    logic [RecipW-1:0] m;
    case (d)
      5'd1:    m = 17'd65536;
      5'd2:    m = 17'd32768;
      5'd3:    m = 17'd21845;
      5'd4:    m = 17'd16384;
      5'd5:    m = 17'd13107;
      5'd6:    m = 17'd10922;
      5'd7:    m = 17'd9362;
      5'd8:    m = 17'd8192;
      5'd9:    m = 17'd7281;
      5'd10:   m = 17'd6553;
      5'd11:   m = 17'd5957;
      5'd12:   m = 17'd5461;
      5'd13:   m = 17'd5041;
      5'd14:   m = 17'd4681;
      5'd15:   m = 17'd4369;
      5'd16:   m = 17'd4096;
      5'd17:   m = 17'd3855;
      5'd18:   m = 17'd3640;
      5'd19:   m = 17'd3449;
      5'd20:   m = 17'd3276;
      5'd21:   m = 17'd3120;
      5'd22:   m = 17'd2978;
      5'd23:   m = 17'd2849;
      default: m = '0;
    endcase
    return m;
  endfunction

  // c + (255 - c) / 5, the divide done as a multiply by 205 and shift by 10
  function automatic logic [ChanW-1:0] lighten(input logic [ChanW-1:0] c);
    logic [ChanW-1:0] gap;
    logic [15:0]      scaled;
    gap    = 8'd255 - c;
    scaled = 16'({8'd0, gap} * 16'd205);
    return c + {2'b00, scaled[15:10]};
  endfunction

endpackage

[rtl/rgb_chan.sv]
`timescale 1ns / 1ps
// rgb_chan: four-stage gradient datapath of one color channel
// depends on rgb_pkg

module rgb_chan import rgb_pkg::*; (
  input  logic               clk_i,
  input  logic [3:0]         ld_i,
  input  logic [RowW-1:0]    row_i,
  input  logic [ChanW-1:0]   top_i,
  input  logic [ChanW-1:0]   bot_i,
  input  logic [HeightW-1:0] div_i,
  input  logic               flat_i,
  output logic [ChanW-1:0]   chan_o
);

  logic signed [ChanW:0] diff;
  logic [ChanW-1:0]      adiff;
  logic [MagW-1:0]       mag1_d, mag1_q, mag2_q;
  logic                  neg1_q, neg2_q, neg3_q;
  logic [ChanW-1:0]      a1_q, a2_q, a3_q;
  logic [ProdW-1:0]      prod2_d, prod2_q;
  logic [MagW-1:0]       qest, rem, q3_d, q3_q;
  logic [17:0]           qdiv;
  logic signed [14:0]    sum;
  logic [ChanW-1:0]      c4_d, c4_q;

  // stage 1: |b - a| * row
  always_comb begin
    diff   = $signed({1'b0, bot_i}) - $signed({1'b0, top_i});
    adiff  = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
    mag1_d = MagW'({5'd0, adiff} * {8'd0, row_i});
  end

  // stage 2: multiply by reciprocal
  assign prod2_d = ProdW'({17'd0, mag1_q} * {13'd0, recip(div_i)});

  // stage 3: quotient estimate with one correction step
  always_comb begin
    qest = prod2_q[RecipShift +: MagW];
    qdiv = 18'({5'd0, qest} * {13'd0, div_i});
    rem  = mag2_q - qdiv[MagW-1:0];
    q3_d = (rem >= {8'd0, div_i}) ? qest + 13'd1 : qest;
  end

  // stage 4: signed add and saturate, or pass the top value through when flat
  always_comb begin
    if (neg3_q) begin
      sum = $signed({7'd0, a3_q}) - $signed({2'd0, q3_q});
    end else begin
      sum = $signed({7'd0, a3_q}) + $signed({2'd0, q3_q});
    end
    if (flat_i) begin
      c4_d = a3_q;
    end else if (sum < 0) begin
      c4_d = '0;
    end else if (sum > 15'sd255) begin
      c4_d = 8'd255;
    end else begin
      c4_d = sum[ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      mag1_q <= mag1_d;
      neg1_q <= diff[ChanW];
      a1_q   <= top_i;
    end
    if (ld_i[1]) begin
      prod2_q <= prod2_d;
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      a2_q    <= a1_q;
    end
    if (ld_i[2]) begin
      q3_q   <= q3_d;
      neg3_q <= neg2_q;
      a3_q   <= a2_q;
    end
    if (ld_i[3]) begin
      c4_q <= c4_d;
    end
  end

  assign chan_o = c4_q;

endmodule

[rtl/rgb_geom.sv]
`timescale 1ns / 1ps
// rgb_geom: cap, stripe, border and size checks, delayed to line up with the channels
// depends on rgb_pkg

module rgb_geom import rgb_pkg::*; (
  input  logic               clk_i,
  input  logic [3:0]         ld_i,
  input  logic [ColW-1:0]    column_i,
  input  logic [RowW-1:0]    row_i,
  input  logic [WidthW-1:0]  bar_width_i,
  input  logic [HeightW-1:0] bar_height_i,
  input  logic               rounded_i,
  input  logic               pattern_i,
  output geo_flags_t         flags_o
);

  logic [3:0]        r;
  logic signed [7:0] wr, xs, dxr;
  logic signed [6:0] dys;
  logic              left, right;
  logic [3:0]        dxl;
  logic [6:0]        dx;
  logic [5:0]        dyabs;
  logic [12:0]       dx2_d, dx2_q;
  logic [10:0]       dy2_d, dy2_q;
  logic [7:0]        rr_d, rr_q;
  logic              cap1_q;
  logic              in_circle;
  geo_flags_t        f1_d, f1_q, f2_d, f2_q, f3_q, f4_q;

  // stage 1: distances from the cap centers and the radius, squared, and the error, stripe and border flags
  always_comb begin
    r      = bar_height_i[HeightW-1:1];
    wr     = $signed({1'b0, bar_width_i}) - $signed({4'd0, r});
    xs     = $signed({2'd0, column_i});
    left   = column_i < {2'd0, r};
    right  = !left && (xs >= wr);
    dxl    = r - column_i[3:0] - 4'd1;
    dxr    = xs - wr;
    dx     = left ? {3'd0, dxl} : dxr[6:0];
    dys    = $signed({3'd0, r}) - $signed({2'd0, row_i}) - 7'sd1;
    dyabs  = dys[6] ? 6'(-dys) : dys[5:0];
    dx2_d  = 13'({6'd0, dx} * {6'd0, dx});
    dy2_d  = 11'({5'd0, dyabs} * {5'd0, dyabs});
    rr_d   = 8'({4'd0, r} * {4'd0, r});

    f1_d.err    = (bar_width_i > WidthW'(MaxWidth)) || (bar_height_i > HeightW'(MaxHeight));
    f1_d.hide   = 1'b0;
    f1_d.stripe = pattern_i && !column_i[2] && (column_i > {2'd0, r}) && (xs < wr);
    f1_d.border = (row_i == '0) || ({1'b0, row_i} + 6'd1 == {1'b0, bar_height_i}) ||
                  (column_i == '0) || ({1'b0, column_i} + 7'd1 == bar_width_i);
  end

  // stage 2: quarter-circle test
  always_comb begin
    in_circle = ({1'b0, dx2_q} + {3'd0, dy2_q}) <= {6'd0, rr_q};
    f2_d      = f1_q;
    f2_d.hide = cap1_q && !in_circle;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      dx2_q  <= dx2_d;
      dy2_q  <= dy2_d;
      rr_q   <= rr_d;
      cap1_q <= rounded_i && (left || right);
      f1_q   <= f1_d;
    end
    if (ld_i[1]) begin
      f2_q <= f2_d;
    end
    if (ld_i[2]) begin
      f3_q <= f2_q;
    end
    if (ld_i[3]) begin
      f4_q <= f3_q;
    end
  end

  assign flags_o = f4_q;

endmodule

[rtl/rounded_gradient_bar_pixel_generator_unit.sv]
`timescale 1ns / 1ps
// rounded_gradient_bar_pixel_generator_unit: top level with config registers and stage control
// depends on rgb_pkg, rgb_chan, rgb_geom

// Gives one RGBA pixel of a rounded gradient bar for each (column, row) word.
// The datapath is five register stages deep, and a new word can be taken every
// cycle while the output is not stalled, so the sustained rate is one pixel per
// clock. Each stage advances on its own when empty or when the next stage moves,
// so a stalled output only holds back the words behind it. The gradient divide
// by (height - 1) uses a reciprocal table, a multiply and one correction step
// over stages two and three. Configuration writes take effect at once and are
// meant for idle periods.

module rounded_gradient_bar_pixel_generator_unit import rgb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ColorW-1:0]  cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // column[5:0], row[10:6]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // red, green, blue, alpha
  output logic               m_axis_tuser    // size_error
);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [ColorW-1:0]  top_q, bottom_q, border_q;
  logic               rounded_q, pattern_q;

  logic [Stages-1:0]  vld_d, vld_q, rdy;
  logic [ColW-1:0]    column;
  logic [RowW-1:0]    row;
  logic [HeightW-1:0] div;
  logic               flat;
  logic [ChanW-1:0]   chan [NumChan];
  geo_flags_t         flags;
  logic [31:0]        tdata_d, tdata_q;
  logic               tuser_d, tuser_q;

  assign column = s_axis_tdata[ColW-1:0];
  assign row    = s_axis_tdata[ColW +: RowW];
  assign div    = height_q - 5'd1;
  assign flat   = height_q <= 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 7'd32;
      height_q  <= 5'd12;
      top_q     <= '0;
      bottom_q  <= '0;
      border_q  <= '0;
      rounded_q <= 1'b0;
      pattern_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBarWidth:    width_q   <= cfg_data_i[WidthW-1:0];
        CfgBarHeight:   height_q  <= cfg_data_i[HeightW-1:0];
        CfgTopColor:    top_q     <= cfg_data_i;
        CfgBottomColor: bottom_q  <= cfg_data_i;
        CfgBorderColor: border_q  <= cfg_data_i;
        CfgRoundedMode: rounded_q <= cfg_data_i[0];
        CfgPatternMode: pattern_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage advance chain
  always_comb begin
    rdy[Stages-1] = !vld_q[Stages-1] || m_axis_tready;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < Stages; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  for (genvar g = 0; g < NumChan; g++) begin : g_chan
    rgb_chan u_chan (
      .clk_i  (clk_i),
      .ld_i   (rdy[3:0]),
      .row_i  (row),
      .top_i  (top_q[ColorW-1-ChanW*g -: ChanW]),
      .bot_i  (bottom_q[ColorW-1-ChanW*g -: ChanW]),
      .div_i  (div),
      .flat_i (flat),
      .chan_o (chan[g])
    );
  end

  rgb_geom u_geom (
    .clk_i        (clk_i),
    .ld_i         (rdy[3:0]),
    .column_i     (column),
    .row_i        (row),
    .bar_width_i  (width_q),
    .bar_height_i (height_q),
    .rounded_i    (rounded_q),
    .pattern_i    (pattern_q),
    .flags_o      (flags)
  );

  // stage 5: stripe, border and masking
  always_comb begin
    tdata_d = '0;
    tuser_d = flags.err;
    for (int c = 0; c < NumChan; c++) begin
      if (flags.err || flags.hide) begin
        tdata_d[ChanW*c +: ChanW] = '0;
      end else if (flags.border) begin
        tdata_d[ChanW*c +: ChanW] = border_q[ColorW-1-ChanW*c -: ChanW];
      end else if (flags.stripe) begin
        tdata_d[ChanW*c +: ChanW] = lighten(chan[c]);
      end else begin
        tdata_d[ChanW*c +: ChanW] = chan[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[Stages-1]) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[Stages-1];
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready while output register empty");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("size error word carries nonzero pixel");

  a_out_from_stage4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[3]))
    else $error("output valid without a word in stage four");

  a_stage4_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && !rdy[4] |=> vld_q[3])
    else $error("stage four word lost during stall");
`endif

endmodule
